// ===== rtl/core/ycrop_pkg.sv =====
// shared types and constants for the 4:2:2 to rgb24 crop converter
package ycrop_pkg;

    localparam int POS_W      = 14;
    localparam int TERM_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHROMA_ORDER = 3'd0,
        CFG_LINE_PAIRS   = 3'd1,
        CFG_FRAME_LINES  = 3'd2,
        CFG_CROP_LEFT    = 3'd3,
        CFG_CROP_TOP     = 3'd4,
        CFG_CROP_WIDTH   = 3'd5,
        CFG_CROP_HEIGHT  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] line_pairs;
        logic [12:0] frame_lines;
        logic [10:0] crop_left;
        logic [11:0] crop_top;
        logic [11:0] crop_width;
        logic [12:0] crop_height;
    } t_win_cfg;

    typedef struct packed {
        logic in_win;
        logic line_done;
        logic frame_done;
    } t_win_flags;

    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } t_cterms;

    localparam logic [11:0] RST_LINE_PAIRS  = 12'd320;
    localparam logic [12:0] RST_FRAME_LINES = 13'd480;
    localparam logic [11:0] RST_CROP_WIDTH  = 12'd320;
    localparam logic [12:0] RST_CROP_HEIGHT = 13'd480;

endpackage

// ===== rtl/core/ycrop_chroma.sv =====
// shared chroma terms for both pixels of a macropixel
module ycrop_chroma (
    input  logic               i_chroma_order,
    input  logic [7:0]         i_chroma_first,
    input  logic [7:0]         i_chroma_second,
    output ycrop_pkg::t_cterms o_terms
);
    import ycrop_pkg::*;

    logic [7:0]         u;
    logic [7:0]         v;
    logic signed [8:0]  du;
    logic signed [8:0]  dv;
    logic signed [16:0] p_b;
    logic signed [11:0] p_g;
    logic signed [9:0]  p_r;

    always_comb begin
        u   = i_chroma_order ? i_chroma_second : i_chroma_first;
        v   = i_chroma_order ? i_chroma_first : i_chroma_second;
        du  = $signed({1'b0, u}) - 9'sd128;
        dv  = $signed({1'b0, v}) - 9'sd128;
        p_b = $signed({{8{du[8]}}, du}) * 17'sd129;
        p_g = $signed({{3{du[8]}}, du}) * 12'sd3 + $signed({{3{dv[8]}}, dv}) * 12'sd6;
        p_r = $signed({dv[8], dv}) * 10'sd3;
        // floor shifts are plain bit selects in two's complement
        o_terms.blue  = $signed(p_b[15:6]);
        o_terms.green = $signed({p_g[11], p_g[11:3]});
        o_terms.red   = $signed({p_r[9], p_r[9:1]});
    end

endmodule

// ===== rtl/core/ycrop_lane.sv =====
// one pixel lane: luma plus chroma terms, clipped to 8 bits
module ycrop_lane (
    input  logic               i_luma,
    input  logic [7:0]         i_y,
    input  ycrop_pkg::t_cterms i_terms,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);
    import ycrop_pkg::*;

    logic signed [TERM_W:0] ys;
    logic signed [TERM_W:0] s_r;
    logic signed [TERM_W:0] s_g;
    logic signed [TERM_W:0] s_b;

    function automatic logic [7:0] clip8(input logic signed [TERM_W:0] s);
        logic [7:0] r;
        if (s < 0) begin
            r = 8'd0;
        end else if (s > 255) begin
            r = 8'hff;
        end else begin
            r = s[7:0];
        end
        return r;
    endfunction

    always_comb begin
        ys  = $signed({3'b000, i_y});
        s_r = ys + $signed({i_terms.red[TERM_W-1], i_terms.red});
        s_g = ys - $signed({i_terms.green[TERM_W-1], i_terms.green});
        s_b = ys + $signed({i_terms.blue[TERM_W-1], i_terms.blue});
        o_red   = clip8(s_r);
        o_green = clip8(s_g);
        o_blue  = i_luma ? clip8(s_b) : clip8(s_b);
    end

endmodule

// ===== rtl/core/ycrop_window.sv =====
// column and line counters with the clamped crop window
module ycrop_window #(
    parameter int MAX_LINE_PAIRS  = 2048,
    parameter int MAX_FRAME_LINES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ycrop_pkg::t_win_cfg   i_cfg,
    input  logic                  i_cfg_wr,
    input  logic                  i_step,
    output ycrop_pkg::t_win_flags o_flags,
    output logic                  o_busy
);
    import ycrop_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PAIRS);
    localparam int ROW_W = $clog2(MAX_FRAME_LINES);
    localparam logic [POS_W-1:0] MAX_LP = POS_W'(MAX_LINE_PAIRS);
    localparam logic [POS_W-1:0] MAX_FL = POS_W'(MAX_FRAME_LINES);
    localparam logic [POS_W-1:0] ONE    = POS_W'(1);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_busy, n_busy;
    logic [POS_W-1:0] r_lp, n_lp;
    logic [POS_W-1:0] r_fl, n_fl;
    logic [POS_W-1:0] r_col_end, n_col_end;
    logic [POS_W-1:0] r_row_end, n_row_end;
    logic [POS_W-1:0] lp_in, fl_in, col_sum, row_sum;
    logic [POS_W-1:0] col_ext, row_ext, col_nx, row_nx;

    // after any register write the bounds settle through the clamped size registers, then the window end registers
    always_comb begin
        lp_in   = POS_W'(i_cfg.line_pairs);
        fl_in   = POS_W'(i_cfg.frame_lines);
        n_lp    = (lp_in == '0) ? ONE : ((lp_in > MAX_LP) ? MAX_LP : lp_in);
        n_fl    = (fl_in == '0) ? ONE : ((fl_in > MAX_FL) ? MAX_FL : fl_in);
        col_sum = POS_W'(i_cfg.crop_left) + POS_W'(i_cfg.crop_width);
        row_sum = POS_W'(i_cfg.crop_top) + POS_W'(i_cfg.crop_height);
        n_col_end = (col_sum > r_lp) ? r_lp : col_sum;
        n_row_end = (row_sum > r_fl) ? r_fl : row_sum;
        n_busy  = i_cfg_wr ? 2'd2 : ((r_busy != 2'd0) ? r_busy - 2'd1 : 2'd0);
    end

    always_comb begin
        col_ext = POS_W'(r_col);
        row_ext = POS_W'(r_row);
        col_nx  = col_ext + ONE;
        row_nx  = row_ext + ONE;
        o_flags.in_win = (col_ext >= POS_W'(i_cfg.crop_left)) && (col_ext < r_col_end) &&
                         (row_ext >= POS_W'(i_cfg.crop_top)) && (row_ext < r_row_end);
        o_flags.line_done  = (col_nx == r_col_end);
        o_flags.frame_done = (col_nx == r_col_end) && (row_nx == r_row_end);
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (col_nx >= r_lp) begin
                n_col = '0;
                n_row = (row_nx >= r_fl) ? '0 : row_nx[ROW_W-1:0];
            end else begin
                n_col = col_nx[COL_W-1:0];
                n_row = (row_ext >= r_fl) ? '0 : r_row;
            end
        end
        o_busy = (r_busy != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_busy <= 2'd2;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lp      <= n_lp;
        r_fl      <= n_fl;
        r_col_end <= n_col_end;
        r_row_end <= n_row_end;
    end

endmodule

// ===== rtl/core/yuv422_to_rgb24_crop.sv =====
// top level: 4:2:2 macropixel to two rgb24 pixels inside a crop window
// an accepted in-window word passes the stage 1 registers, then the output registers
// throughput: one macropixel per cycle through the two-stage pipeline when not stalled
// after a register write input ready drops while the window bounds settle
// synchronous active-low reset empties the pipeline, zeroes the counters, restores
// register defaults and holds input ready low after release while bounds settle
module yuv422_to_rgb24_crop #(
    parameter int MAX_LINE_PAIRS  = 2048,
    parameter int MAX_FRAME_LINES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ycrop_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ycrop_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_luma_first,
    input  logic [7:0]                       i_chroma_first,
    input  logic [7:0]                       i_luma_second,
    input  logic [7:0]                       i_chroma_second,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_red_first,
    output logic [7:0]                       o_green_first,
    output logic [7:0]                       o_blue_first,
    output logic [7:0]                       o_red_second,
    output logic [7:0]                       o_green_second,
    output logic [7:0]                       o_blue_second,
    output logic                             o_line_done,
    output logic                             o_frame_done
);
    import ycrop_pkg::*;

    logic       r_chroma_order;
    t_win_cfg   r_cfg;
    logic       cfg_wr;
    logic       in_acc;
    logic       win_busy;
    t_win_flags win_flags;
    t_cterms    terms;

    logic       r_s1_valid;
    logic [7:0] r_s1_y0, r_s1_y1;
    t_cterms    r_s1_terms;
    logic       r_s1_ld, r_s1_fd;
    logic       s2_free, s1_free;

    logic [7:0] l0_r, l0_g, l0_b, l1_r, l1_g, l1_b;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign s2_free     = !o_out_valid || i_out_ready;
    assign s1_free     = !r_s1_valid || s2_free;
    assign o_in_ready  = s1_free && !win_busy;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_order    <= 1'b0;
            r_cfg.line_pairs  <= RST_LINE_PAIRS;
            r_cfg.frame_lines <= RST_FRAME_LINES;
            r_cfg.crop_left   <= '0;
            r_cfg.crop_top    <= '0;
            r_cfg.crop_width  <= RST_CROP_WIDTH;
            r_cfg.crop_height <= RST_CROP_HEIGHT;
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CHROMA_ORDER: r_chroma_order    <= i_cfg_data[0];
                CFG_LINE_PAIRS:   r_cfg.line_pairs  <= i_cfg_data[11:0];
                CFG_FRAME_LINES:  r_cfg.frame_lines <= i_cfg_data[12:0];
                CFG_CROP_LEFT:    r_cfg.crop_left   <= i_cfg_data[10:0];
                CFG_CROP_TOP:     r_cfg.crop_top    <= i_cfg_data[11:0];
                CFG_CROP_WIDTH:   r_cfg.crop_width  <= i_cfg_data[11:0];
                CFG_CROP_HEIGHT:  r_cfg.crop_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ycrop_window #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS),
        .MAX_FRAME_LINES(MAX_FRAME_LINES)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cfg_wr(cfg_wr),
        .i_step  (in_acc),
        .o_flags (win_flags),
        .o_busy  (win_busy)
    );

    ycrop_chroma u_chroma (
        .i_chroma_order (r_chroma_order),
        .i_chroma_first (i_chroma_first),
        .i_chroma_second(i_chroma_second),
        .o_terms        (terms)
    );

    // stage 1: chroma terms and window flags for words inside the crop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc && win_flags.in_win) begin
            r_s1_valid <= 1'b1;
        end else if (s2_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && win_flags.in_win) begin
            r_s1_y0    <= i_luma_first;
            r_s1_y1    <= i_luma_second;
            r_s1_terms <= terms;
            r_s1_ld    <= win_flags.line_done;
            r_s1_fd    <= win_flags.frame_done;
        end
    end

    ycrop_lane u_lane0 (
        .i_luma (1'b0),
        .i_y    (r_s1_y0),
        .i_terms(r_s1_terms),
        .o_red  (l0_r),
        .o_green(l0_g),
        .o_blue (l0_b)
    );

    ycrop_lane u_lane1 (
        .i_luma (1'b1),
        .i_y    (r_s1_y1),
        .i_terms(r_s1_terms),
        .o_red  (l1_r),
        .o_green(l1_g),
        .o_blue (l1_b)
    );

    // stage 2: merge both lanes and the flags into the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s2_free) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            o_red_first    <= l0_r;
            o_green_first  <= l0_g;
            o_blue_first   <= l0_b;
            o_red_second   <= l1_r;
            o_green_second <= l1_g;
            o_blue_second  <= l1_b;
            o_line_done    <= r_s1_ld;
            o_frame_done   <= r_s1_fd;
        end
    end

endmodule

// ===== rtl/core/ycrop_chk.sv =====
// port-level checks for the converter, bound to the top level
module ycrop_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [ycrop_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [ycrop_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [7:0]                       o_red_first,
    input logic [7:0]                       o_green_first,
    input logic [7:0]                       o_blue_first,
    input logic [7:0]                       o_red_second,
    input logic [7:0]                       o_green_second,
    input logic [7:0]                       o_blue_second,
    input logic                             o_line_done,
    input logic                             o_frame_done
);
    import ycrop_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_first) &&
        $stable(o_green_first) && $stable(o_blue_first) && $stable(o_red_second) &&
        $stable(o_green_second) && $stable(o_blue_second) && $stable(o_line_done) &&
        $stable(o_frame_done))
        else $error("stalled output word changed");

    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_line_done)
        else $error("frame end without line end");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("input taken while window bounds settle");

endmodule

bind yuv422_to_rgb24_crop ycrop_chk u_ycrop_chk (.*);

// ===== tb/sv/yuv422_to_rgb24_crop_tb.sv =====
// self-checking testbench for the 4:2:2 to rgb24 crop converter
`timescale 1ns / 1ps

module yuv422_to_rgb24_crop_tb;
    import ycrop_pkg::*;

    localparam int MAX_LINE_PAIRS  = 2048;
    localparam int MAX_FRAME_LINES = 4096;
    localparam int CHROMA_BIAS     = 128;
    localparam int PIPE_SETTLE     = 4;
    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PIXELS   = 1420;
    localparam int MAX_REPORTS     = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_second;
    } yuyv_word_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       line_done;
        logic       frame_done;
    } rgb_pair_t;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_luma_first    = '0;
    logic [7:0]            i_chroma_first  = '0;
    logic [7:0]            i_luma_second   = '0;
    logic [7:0]            i_chroma_second = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic [7:0]            o_red_first;
    logic [7:0]            o_green_first;
    logic [7:0]            o_blue_first;
    logic [7:0]            o_red_second;
    logic [7:0]            o_green_second;
    logic [7:0]            o_blue_second;
    logic                  o_line_done;
    logic                  o_frame_done;

    // predictor copy of the registers and position counters
    int cfg_order, cfg_line_pairs, cfg_frame_lines;
    int cfg_left, cfg_top, cfg_width, cfg_height;
    int col_pos, row_pos;

    rgb_pair_t pending_rgb[$];
    rgb_pair_t front_rgb;
    int        mismatches     = 0;
    int        sent_pixels    = 0;
    int        quiet_cycles   = 0;
    bit        idle_en        = 1'b1;
    bit        hold_request   = 1'b0;
    int        hold_left      = 0;
    int        stall_left     = 0;

    yuv422_to_rgb24_crop #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS),
        .MAX_FRAME_LINES(MAX_FRAME_LINES)
    ) u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] clamp_byte(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    function automatic int size_or_one(int v, int maxv);
        if (v == 0)
            v = 1;
        if (v > maxv)
            v = maxv;
        return v;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CHROMA_ORDER: cfg_order       = data[0];
            CFG_LINE_PAIRS:   cfg_line_pairs  = data[11:0];
            CFG_FRAME_LINES:  cfg_frame_lines = data[12:0];
            CFG_CROP_LEFT:    cfg_left        = data[10:0];
            CFG_CROP_TOP:     cfg_top         = data[11:0];
            CFG_CROP_WIDTH:   cfg_width       = data[11:0];
            CFG_CROP_HEIGHT:  cfg_height      = data[12:0];
            default: ;
        endcase
    endfunction

    // converts one macropixel if it falls in the window, then moves the position on
    function automatic void convert_pixel(yuyv_word_t p);
        int lp, fl, col_end, row_end, du, dv, blue_t, green_t, red_t, y0, y1, col, row;
        rgb_pair_t r;
        lp      = size_or_one(cfg_line_pairs, MAX_LINE_PAIRS);
        fl      = size_or_one(cfg_frame_lines, MAX_FRAME_LINES);
        col_end = cfg_left + cfg_width;
        row_end = cfg_top + cfg_height;
        if (col_end > lp)
            col_end = lp;
        if (row_end > fl)
            row_end = fl;
        if (col_pos >= cfg_left && col_pos < col_end &&
            row_pos >= cfg_top && row_pos < row_end) begin
            y0      = int'(p.luma_first);
            y1      = int'(p.luma_second);
            du      = int'(cfg_order ? p.chroma_second : p.chroma_first) - CHROMA_BIAS;
            dv      = int'(cfg_order ? p.chroma_first : p.chroma_second) - CHROMA_BIAS;
            blue_t  = (129 * du) >>> 6;
            green_t = (3 * du + 6 * dv) >>> 3;
            red_t   = (3 * dv) >>> 1;
            r.red_first    = clamp_byte(y0 + red_t);
            r.green_first  = clamp_byte(y0 - green_t);
            r.blue_first   = clamp_byte(y0 + blue_t);
            r.red_second   = clamp_byte(y1 + red_t);
            r.green_second = clamp_byte(y1 - green_t);
            r.blue_second  = clamp_byte(y1 + blue_t);
            r.line_done    = (col_pos + 1 == col_end);
            r.frame_done   = r.line_done && (row_pos + 1 == row_end);
            pending_rgb.push_back(r);
        end
        col = col_pos + 1;
        row = row_pos;
        if (col >= lp) begin
            col = 0;
            row++;
            if (row >= fl)
                row = 0;
        end else if (row >= fl) begin
            row = 0;
        end
        col_pos = col;
        row_pos = row;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'(CHROMA_BIAS);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic yuyv_word_t random_pixel();
        yuyv_word_t p;
        p.luma_first    = pick_byte();
        p.chroma_first  = pick_byte();
        p.luma_second   = pick_byte();
        p.chroma_second = pick_byte();
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // called and returns at a falling edge; leaves valid high for back-to-back words
    task automatic send_pixel(yuyv_word_t p);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_luma_first    <= p.luma_first;
        i_chroma_first  <= p.chroma_first;
        i_luma_second   <= p.luma_second;
        i_chroma_second <= p.chroma_second;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        convert_pixel(p);
        sent_pixels++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge i_clk);
        // words outside the window may still be in flight
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        store_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] order, logic [CFG_DATA_W-1:0] lp,
                                logic [CFG_DATA_W-1:0] fl, logic [CFG_DATA_W-1:0] left,
                                logic [CFG_DATA_W-1:0] top, logic [CFG_DATA_W-1:0] width,
                                logic [CFG_DATA_W-1:0] height);
        wait_idle();
        write_reg(CFG_CHROMA_ORDER, order);
        write_reg(CFG_LINE_PAIRS, lp);
        write_reg(CFG_FRAME_LINES, fl);
        write_reg(CFG_CROP_LEFT, left);
        write_reg(CFG_CROP_TOP, top);
        write_reg(CFG_CROP_WIDTH, width);
        write_reg(CFG_CROP_HEIGHT, height);
    endtask

    // reset settings: yuyv order, full 320x480 window
    task automatic test_color_extremes();
        send_pixel({8'h00, 8'h00, 8'h00, 8'h00});
        send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pixel({8'h00, 8'hFF, 8'hFF, 8'h00});
        send_pixel({8'hFF, 8'h00, 8'h00, 8'hFF});
        send_pixel({8'd128, 8'd128, 8'd128, 8'd128});
        send_pixel({8'd16, 8'd127, 8'd235, 8'd129});
    endtask

    task automatic test_yvyu_order();
        set_geometry(1, 320, 480, 0, 0, 320, 480);
        send_pixel({8'h00, 8'hFF, 8'hFF, 8'h00});
        send_pixel({8'hFF, 8'h00, 8'h00, 8'hFF});
        send_pixel({8'd90, 8'd60, 8'd200, 8'd240});
    endtask

    // counters sit past the shrunk frame and wrap on the next word
    task automatic test_window_flags();
        set_geometry(0, 3, 3, 1, 1, 2, 2);
        repeat (10) send_pixel(random_pixel());
    endtask

    task automatic test_clamped_window();
        set_geometry(1, 4, 2, 2, 1, 4095, 8191);
        repeat (8) send_pixel(random_pixel());
    endtask

    task automatic test_empty_window();
        set_geometry(0, 4, 2, 4, 0, 2, 2);
        repeat (4) send_pixel(random_pixel());
        set_geometry(0, 2, 2, 0, 0, 0, 0);
        repeat (4) send_pixel(random_pixel());
    endtask

    // zero sizes read as a 1x1 frame, every word ends line and frame
    task automatic test_zero_frame_size();
        set_geometry(0, 0, 0, 0, 0, 1, 1);
        repeat (2) send_pixel(random_pixel());
    endtask

    task automatic test_unknown_register();
        wait_idle();
        write_reg(CFG_UNUSED, 13'h1FFF);
        repeat (2) send_pixel(random_pixel());
    endtask

    // sink holds off long enough for the pipeline to fill and stall the source
    task automatic test_backpressure();
        set_geometry(0, 8, 4, 0, 0, 8, 4);
        idle_en      = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_pixel(random_pixel());
        idle_en = 1'b1;
    endtask

    task automatic test_random_frames();
        int base, lp, fl;
        base = sent_pixels;
        while (sent_pixels - base < RANDOM_PIXELS) begin
            idle_en = (sent_pixels - base) < RANDOM_PIXELS - 200;
            if ($urandom_range(0, 5) == 0) begin
                set_geometry(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom));
            end else begin
                lp = $urandom_range(1, 10);
                fl = $urandom_range(1, 6);
                set_geometry(CFG_DATA_W'($urandom_range(0, 1)), CFG_DATA_W'(lp),
                             CFG_DATA_W'(fl), CFG_DATA_W'($urandom_range(0, lp - 1)),
                             CFG_DATA_W'($urandom_range(0, fl - 1)),
                             CFG_DATA_W'($urandom_range(1, lp + 2)),
                             CFG_DATA_W'($urandom_range(1, fl + 2)));
            end
            repeat ($urandom_range(30, 90)) send_pixel(random_pixel());
        end
    endtask

    // sink side ready, with random stall bursts and the long hold-off
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rgb.size() == 0) begin
                report_mismatch("unexpected rgb word, words waiting", 0, 0);
            end else begin
                front_rgb = pending_rgb.pop_front();
                check_field("red_first", o_red_first, front_rgb.red_first);
                check_field("green_first", o_green_first, front_rgb.green_first);
                check_field("blue_first", o_blue_first, front_rgb.blue_first);
                check_field("red_second", o_red_second, front_rgb.red_second);
                check_field("green_second", o_green_second, front_rgb.green_second);
                check_field("blue_second", o_blue_second, front_rgb.blue_second);
                check_field("line_done", o_line_done, front_rgb.line_done);
                check_field("frame_done", o_frame_done, front_rgb.frame_done);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("yuv422_to_rgb24_crop regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_order       = 0;
        cfg_line_pairs  = RST_LINE_PAIRS;
        cfg_frame_lines = RST_FRAME_LINES;
        cfg_left        = 0;
        cfg_top         = 0;
        cfg_width       = RST_CROP_WIDTH;
        cfg_height      = RST_CROP_HEIGHT;
        col_pos         = 0;
        row_pos         = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_color_extremes();
        test_yvyu_order();
        test_window_flags();
        test_clamped_window();
        test_empty_window();
        test_zero_frame_size();
        test_unknown_register();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (mismatches == 0)
            $display("yuv422_to_rgb24_crop regression: pass");
        else
            $display("yuv422_to_rgb24_crop regression: fail");
        $finish;
    end

endmodule
